@@ src/mss_pkg.sv @@
package mss_pkg;

	localparam int unsigned MinutesW   = 7;
	localparam int unsigned SecondsW   = 6;
	localparam int unsigned DeltaW     = 8;
	localparam int unsigned FuncW      = 3;

	localparam logic [MinutesW-1:0] MaxMinutes = 7'd99;
	localparam logic [SecondsW-1:0] MaxSeconds = 6'd59;

	typedef enum logic [1:0] {
		MODE_PAUSED   = 2'd0,
		MODE_STARTING = 2'd1,
		MODE_RUNNING  = 2'd2
	} mode_t;

	typedef enum logic [FuncW-1:0] {
		FN_TICK       = 3'd0,
		FN_START      = 3'd1,
		FN_PAUSE      = 3'd2,
		FN_ADJ_SEC    = 3'd3,
		FN_ADJ_MIN    = 3'd4,
		FN_SET_TIME   = 3'd5
	} func_t;

	typedef struct packed {
		logic [MinutesW-1:0] minutes;
		logic [SecondsW-1:0] seconds;
		mode_t               mode;
	} tmr_state_t;

endpackage

@@ src/minute_second_countdown_timer.sv @@
// Minutes:seconds countdown timer, one event per input beat.
// Input channel: in_valid/in_stall with func, delta, set_minutes, set_seconds.
// Output channel: out_valid/out_stall with completed, minutes_now,
// seconds_now and run_state; every input beat yields exactly one output beat.
// Path: an accepted beat enters the input register and then moves into the
// result register, where out_valid rises; the move waits while out_stall
// holds a result. Throughput: one beat per cycle unless out_stall holds a
// result; the event logic between the two registers is a single pass, and
// the timer state updates when the beat moves into the result register.
// Stall: while out_stall holds a waiting result, the input register keeps one
// more beat and in_stall rises only once both registers are full.
// Reset (arst_n low): both registers empty, time 0:00, run state paused.
module minute_second_countdown_timer
	import mss_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [FuncW-1:0]           func,
	input  logic signed [DeltaW-1:0]   delta,
	input  logic [MinutesW-1:0]        set_minutes,
	input  logic [SecondsW-1:0]        set_seconds,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       completed,
	output logic [MinutesW-1:0]        minutes_now,
	output logic [SecondsW-1:0]        seconds_now,
	output logic [1:0]                 run_state
);

	logic                      valid_s1;
	logic [FuncW-1:0]          func_s1;
	logic signed [DeltaW-1:0]  delta_s1;
	logic [MinutesW-1:0]       setm_s1;
	logic [SecondsW-1:0]       sets_s1;

	logic                      valid_s2;
	logic                      done_s2;
	tmr_state_t                res_s2;

	tmr_state_t                state_q;
	tmr_state_t                state_nxt;
	logic                      done_nxt;
	logic                      advance;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	mss_next u_next (
		.cur         (state_q),
		.func        (func_s1),
		.delta       (delta_s1),
		.set_minutes (setm_s1),
		.set_seconds (sets_s1),
		.nxt         (state_nxt),
		.done        (done_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1  <= func;
			delta_s1 <= delta;
			setm_s1  <= set_minutes;
			sets_s1  <= set_seconds;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			state_q  <= '{minutes: '0, seconds: '0, mode: MODE_PAUSED};
		end else if (advance) begin
			valid_s2 <= 1'b1;
			state_q  <= state_nxt;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2  <= state_nxt;
			done_s2 <= done_nxt;
		end
	end

	assign out_valid   = valid_s2;
	assign completed   = done_s2;
	assign minutes_now = res_s2.minutes;
	assign seconds_now = res_s2.seconds;
	assign run_state   = res_s2.mode;

	// a completion beat always shows a paused timer at 0:00
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && completed |-> minutes_now == '0 && seconds_now == '0
			&& run_state == MODE_PAUSED)
		else $error("completion beat without paused 0:00");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.minutes <= MaxMinutes && state_q.seconds <= MaxSeconds)
		else $error("timer state out of range");

	// the input side backs up only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled without a held result");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("timer state moved without a beat");

endmodule

@@ src/mss_next.sv @@
module mss_next
	import mss_pkg::*;
(
	input  tmr_state_t                 cur,
	input  logic [FuncW-1:0]           func,
	input  logic signed [DeltaW-1:0]   delta,
	input  logic [MinutesW-1:0]        set_minutes,
	input  logic [SecondsW-1:0]        set_seconds,
	output tmr_state_t                 nxt,
	output logic                       done
);

	logic signed [8:0] sec_sum;
	logic signed [8:0] sec_fold;
	logic signed [8:0] carry;
	logic signed [8:0] min_dm;
	logic signed [8:0] min_sum;
	logic [MinutesW-1:0] min_adj;
	logic paused;
	logic active;

	assign paused = (cur.mode == MODE_PAUSED);
	assign active = (cur.mode == MODE_STARTING) || (cur.mode == MODE_RUNNING);

	// fold seconds + delta into 0..59, carry spans -3..3
	assign sec_sum = $signed({3'b000, cur.seconds}) + $signed({delta[DeltaW-1], delta});

	always_comb begin
		if (sec_sum >= 9'sd180) begin
			carry    = 9'sd3;
			sec_fold = sec_sum - 9'sd180;
		end else if (sec_sum >= 9'sd120) begin
			carry    = 9'sd2;
			sec_fold = sec_sum - 9'sd120;
		end else if (sec_sum >= 9'sd60) begin
			carry    = 9'sd1;
			sec_fold = sec_sum - 9'sd60;
		end else if (sec_sum >= 9'sd0) begin
			carry    = 9'sd0;
			sec_fold = sec_sum;
		end else if (sec_sum >= -9'sd60) begin
			carry    = -9'sd1;
			sec_fold = sec_sum + 9'sd60;
		end else if (sec_sum >= -9'sd120) begin
			carry    = -9'sd2;
			sec_fold = sec_sum + 9'sd120;
		end else begin
			carry    = -9'sd3;
			sec_fold = sec_sum + 9'sd180;
		end
	end

	// saturate at 99, drop a change that goes negative
	assign min_dm  = (func == FN_ADJ_SEC) ? carry : $signed({delta[DeltaW-1], delta});
	assign min_sum = $signed({2'b00, cur.minutes}) + min_dm;

	always_comb begin
		if (min_sum > $signed({2'b00, MaxMinutes}))
			min_adj = MaxMinutes;
		else if (min_sum >= 9'sd0)
			min_adj = min_sum[MinutesW-1:0];
		else
			min_adj = cur.minutes;
	end

	always_comb begin
		nxt  = cur;
		done = 1'b0;
		unique case (func)
			FN_TICK: begin
				if (cur.mode == MODE_STARTING) begin
					nxt.mode = MODE_RUNNING;
				end else if (cur.mode == MODE_RUNNING) begin
					if (cur.minutes == '0 && cur.seconds <= 6'd1) begin
						nxt.minutes = '0;
						nxt.seconds = '0;
						nxt.mode    = MODE_PAUSED;
						done        = 1'b1;
					end else if (cur.seconds == '0) begin
						nxt.minutes = cur.minutes - 7'd1;
						nxt.seconds = MaxSeconds;
					end else begin
						nxt.seconds = cur.seconds - 6'd1;
					end
				end
			end
			FN_START: begin
				if (paused)
					nxt.mode = MODE_STARTING;
			end
			FN_PAUSE: begin
				if (active)
					nxt.mode = MODE_PAUSED;
			end
			FN_ADJ_SEC: begin
				if (paused) begin
					nxt.seconds = sec_fold[SecondsW-1:0];
					nxt.minutes = min_adj;
				end
			end
			FN_ADJ_MIN: begin
				if (paused)
					nxt.minutes = min_adj;
			end
			FN_SET_TIME: begin
				if (active)
					nxt.mode = MODE_PAUSED;
				nxt.minutes = (set_minutes > MaxMinutes) ? MaxMinutes : set_minutes;
				nxt.seconds = (set_seconds > MaxSeconds) ? MaxSeconds : set_seconds;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule
